FILE: src/hed_pkg.sv
// Shared types, character codes and pattern lookups for the HTML entity decoder.
// No dependencies; used by hed_decode, hed_emit and html_entity_decoder_core.
package hed_pkg;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_L     = 8'h6C;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [7:0] CH_G     = 8'h67;
	localparam logic [7:0] CH_Q     = 8'h71;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CH_O     = 8'h6F;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_M     = 8'h6D;
	localparam logic [7:0] CH_P     = 8'h70;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_QUOTE = 8'h22;

	localparam logic [1:0] KIND_LT   = 2'd0;
	localparam logic [1:0] KIND_GT   = 2'd1;
	localparam logic [1:0] KIND_QUOT = 2'd2;
	localparam logic [1:0] KIND_AMP  = 2'd3;

	// Longest prefix that can be held (the ampersand plus "quot").
	localparam logic [2:0] MAX_HELD = 3'd5;

	// One decoded job: a prefix of an entity pattern, then an optional extra byte.
	typedef struct packed {
		logic [1:0] kind;
		logic [2:0] plen;
		logic       xv;
		logic [7:0] xbyte;
		logic       last;
	} job_t;

	// Byte idx of the pattern for an entity kind; NUL past the end.
	function automatic logic [7:0] pat_byte(input logic [1:0] kind, input logic [2:0] idx);
		logic [7:0] r;
		r = CH_NUL;
		if (idx == 3'd0) begin
			r = CH_AMP;
		end else begin
			case (kind)
				KIND_LT: begin
					case (idx)
						3'd1: r = CH_L;
						3'd2: r = CH_T;
						3'd3: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				KIND_GT: begin
					case (idx)
						3'd1: r = CH_G;
						3'd2: r = CH_T;
						3'd3: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				KIND_QUOT: begin
					case (idx)
						3'd1: r = CH_Q;
						3'd2: r = CH_U;
						3'd3: r = CH_O;
						3'd4: r = CH_T;
						3'd5: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
				default: begin
					case (idx)
						3'd1: r = CH_A;
						3'd2: r = CH_M;
						3'd3: r = CH_P;
						3'd4: r = CH_SEMI;
						default: r = CH_NUL;
					endcase
				end
			endcase
		end
		return r;
	endfunction

	function automatic logic [7:0] decoded_byte(input logic [1:0] kind);
		logic [7:0] r;
		case (kind)
			KIND_LT:   r = CH_LT;
			KIND_GT:   r = CH_GT;
			KIND_QUOT: r = CH_QUOTE;
			default:   r = CH_AMP;
		endcase
		return r;
	endfunction

endpackage

FILE: src/hed_decode.sv
// Match logic: turns one input byte and the held-prefix state into a job and next state.
// Depends on hed_pkg.
module hed_decode (
	input  logic [7:0]  in_byte,
	input  logic        last_in,
	input  logic [2:0]  ml,
	input  logic [1:0]  kind,
	output logic [2:0]  ml_next,
	output logic [1:0]  kind_next,
	output hed_pkg::job_t job,
	output logic        has_out
);
	import hed_pkg::*;

	logic [2:0] ml_eff;
	logic [7:0] want;
	logic       fresh;

	assign ml_eff = (ml > MAX_HELD) ? 3'd0 : ml;
	assign want   = pat_byte(kind, ml_eff);

	always_comb begin
		ml_next    = ml_eff;
		kind_next  = (ml_eff < 3'd2) ? KIND_LT : kind;
		job.kind   = kind;
		job.plen   = 3'd0;
		job.xv     = 1'b0;
		job.xbyte  = in_byte;
		job.last   = last_in;
		fresh      = 1'b0;

		if (ml_eff == 3'd0) begin
			fresh = 1'b1;
		end else if (ml_eff == 3'd1) begin
			if (in_byte == CH_L) begin
				kind_next = KIND_LT;
				ml_next   = 3'd2;
			end else if (in_byte == CH_G) begin
				kind_next = KIND_GT;
				ml_next   = 3'd2;
			end else if (in_byte == CH_Q) begin
				kind_next = KIND_QUOT;
				ml_next   = 3'd2;
			end else if (in_byte == CH_A) begin
				kind_next = KIND_AMP;
				ml_next   = 3'd2;
			end else begin
				job.plen = 3'd1;
				fresh    = 1'b1;
			end
		end else begin
			if (want != CH_NUL && in_byte == want) begin
				if (want == CH_SEMI) begin
					job.xv    = 1'b1;
					job.xbyte = decoded_byte(kind);
					ml_next   = 3'd0;
					kind_next = KIND_LT;
				end else begin
					ml_next = ml_eff + 3'd1;
				end
			end else begin
				job.plen = ml_eff;
				fresh    = 1'b1;
			end
		end

		// A byte that is not part of a match: an ampersand opens a new one.
		if (fresh) begin
			kind_next = KIND_LT;
			if (in_byte == CH_AMP) begin
				ml_next = 3'd1;
			end else begin
				ml_next   = 3'd0;
				job.xv    = 1'b1;
				job.xbyte = in_byte;
			end
		end

		// End of text flushes whatever is now held.
		if (last_in && ml_next != 3'd0) begin
			if (job.plen == 3'd0) begin
				job.plen = ml_next;
				job.kind = kind_next;
			end else begin
				job.xv    = 1'b1;
				job.xbyte = CH_AMP;
			end
			ml_next   = 3'd0;
			kind_next = KIND_LT;
		end
	end

	assign has_out = (job.plen != 3'd0) || job.xv;

endmodule

FILE: src/hed_emit.sv
// Result register and serializer: sends one job's bytes, one per output transaction.
// Depends on hed_pkg.
module hed_emit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  hed_pkg::job_t job,
	input  logic          out_stall,
	output logic          out_valid,
	output logic [7:0]    out_byte,
	output logic          run_end,
	output logic          text_end,
	output logic          done
);
	import hed_pkg::*;

	job_t       job_q;
	logic       valid_q;
	logic [2:0] idx_q;
	logic [2:0] count;
	logic       fire;

	assign count     = job_q.plen + {2'b00, job_q.xv};
	assign out_valid = valid_q;
	assign out_byte  = (idx_q < job_q.plen) ? pat_byte(job_q.kind, idx_q) : job_q.xbyte;
	assign run_end   = (idx_q == count - 3'd1);
	assign text_end  = run_end && job_q.last;
	assign fire      = valid_q && !out_stall;
	assign done      = fire && run_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (load) begin
			valid_q <= 1'b1;
			idx_q   <= 3'd0;
		end else if (done) begin
			valid_q <= 1'b0;
			idx_q   <= 3'd0;
		end else if (fire) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q <= job;
		end
	end

	// A loaded job always has a byte at the current index.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> (idx_q < count))
		else $error("emit index beyond job length");

	// A new job is only taken when the current one is gone or leaving.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!valid_q || done))
		else $error("job overwritten before it was sent");

endmodule

FILE: src/html_entity_decoder_core.sv
// Top level of the streaming HTML entity decoder (&lt; &gt; &quot; &amp;).
// Depends on hed_pkg, hed_decode and hed_emit.
//
//  channel | handshake             | payload
//  --------+-----------------------+----------------------------------
//  input   | in_valid / in_stall   | in_byte[7:0], last_in
//  output  | out_valid / out_stall | out_byte[7:0], run_end, text_end
//
// Each input transaction is decoded in the cycle it is accepted, and its result
// bytes leave the result register from the next cycle on, one per output transaction.
// Inputs that yield zero or one byte each let plain text stream at one byte per cycle
// while out_stall is low; one that flushes a held prefix yields up to six bytes and
// holds in_stall high until the last of them leaves. Inputs that yield nothing also
// wait while the result register is busy. Reset clears the held prefix and the valid flag.
module html_entity_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       last_in,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       text_end
);
	import hed_pkg::*;

	// Held-prefix state: match length and entity kind.
	logic [2:0] ml_q;
	logic [1:0] kind_q;
	logic [2:0] ml_next;
	logic [1:0] kind_next;
	job_t       job;
	logic       has_out;
	logic       in_fire;
	logic       load;
	logic       done;

	// The result register is free when empty or when its last byte leaves now.
	assign in_stall = out_valid && !done;
	assign in_fire  = in_valid && !in_stall;
	assign load     = in_fire && has_out;

	hed_decode u_decode (
		.in_byte   (in_byte),
		.last_in   (last_in),
		.ml        (ml_q),
		.kind      (kind_q),
		.ml_next   (ml_next),
		.kind_next (kind_next),
		.job       (job),
		.has_out   (has_out)
	);

	hed_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.job       (job),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_byte  (out_byte),
		.run_end   (run_end),
		.text_end  (text_end),
		.done      (done)
	);

	// State advances with every accepted transaction, independent of output drain.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ml_q   <= 3'd0;
			kind_q <= KIND_LT;
		end else if (in_fire) begin
			ml_q   <= ml_next;
			kind_q <= kind_next;
		end
	end

	// The held prefix never grows past the longest entity prefix.
	assert property (@(posedge clk) disable iff (!arst_n)
		ml_q <= MAX_HELD)
		else $error("held prefix too long");

	// The final byte of a text always produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_in) |-> has_out)
		else $error("end of text produced no result");

	// Nothing stays held after the final byte of a text.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && last_in) |=> (ml_q == 3'd0))
		else $error("prefix still held after end of text");

	// A transaction with output is visible on the result side in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		load |=> out_valid)
		else $error("loaded job not presented");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for html_entity_decoder_core: a directed table, then random escaped text.
// Depends on hed_pkg and the decoder RTL; a local model predicts the output bytes of untyped rows.
module testbench;
	import hed_pkg::*;

	localparam int HALF_PERIOD  = 10;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_ITEMS = 444;
	localparam int CALM_TAIL    = 60;
	localparam int DRAIN_CYCLES = 20;
	localparam int MAX_REPORTS  = 10;

	// One decoded byte as it leaves the output channel.
	typedef struct packed {
		logic [7:0] ch;
		logic       run_end;
		logic       text_end;
	} char_t;

	// One input transaction. When typed is set, the expected output is tn copies of tch
	// (only zero or one here) instead of what the local model computes.
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       typed;
		logic [2:0] tn;
		logic [7:0] tch;
	} row_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'h00;
	logic       last_in   = 1'b0;
	logic       out_stall = 1'b0;
	wire        in_stall;
	wire        out_valid;
	wire  [7:0] out_byte;
	wire        run_end;
	wire        text_end;

	html_entity_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.last_in  (last_in),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.run_end  (run_end),
		.text_end (text_end)
	);

	always #HALF_PERIOD clk = ~clk;

	// Local model state: how many bytes of a possible entity are held, and which entity.
	logic [2:0] held_len  = 3'd0;
	logic [1:0] held_kind = KIND_LT;
	logic [7:0] step_chars [6];
	int         step_n;

	char_t decoded_due [$];
	row_t  stimulus [$];
	int    mismatches = 0;
	int    cycles     = 0;
	int    stall_left = 0;
	bit    calm       = 1'b0;

	// Byte idx of the spelling of an entity, NUL past its semicolon.
	function automatic logic [7:0] spelled_char(input logic [1:0] kind, input int idx);
		logic [47:0] s;
		case (kind)
			KIND_LT:   s = {CH_AMP, CH_L, CH_T, CH_SEMI, CH_NUL, CH_NUL};
			KIND_GT:   s = {CH_AMP, CH_G, CH_T, CH_SEMI, CH_NUL, CH_NUL};
			KIND_QUOT: s = {CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI};
			default:   s = {CH_AMP, CH_A, CH_M, CH_P, CH_SEMI, CH_NUL};
		endcase
		return s[47 - 8 * idx -: 8];
	endfunction

	task automatic put_char(input logic [7:0] c);
		if (step_n < 6) begin
			step_chars[step_n] = c;
			step_n++;
		end
	endtask

	// Emit the held prefix verbatim and forget it.
	task automatic release_held();
		int len;
		len = (held_len > MAX_HELD) ? 0 : int'(held_len);
		for (int i = 0; i < len; i++)
			put_char(spelled_char(held_kind, i));
		held_len  = 3'd0;
		held_kind = KIND_LT;
	endtask

	task automatic take_fresh(input logic [7:0] c);
		if (c == CH_AMP) begin
			held_len  = 3'd1;
			held_kind = KIND_LT;
		end else begin
			put_char(c);
		end
	endtask

	// Advance the local model by one input byte; the bytes it causes land in step_chars.
	task automatic decode_step(input logic [7:0] c, input logic last);
		logic [7:0] want;
		step_n = 0;
		if (held_len == 3'd0 || held_len > MAX_HELD) begin
			held_len  = 3'd0;
			held_kind = KIND_LT;
			take_fresh(c);
		end else if (held_len == 3'd1) begin
			if (c == CH_L || c == CH_G || c == CH_Q || c == CH_A) begin
				held_kind = (c == CH_L) ? KIND_LT : (c == CH_G) ? KIND_GT :
				            (c == CH_Q) ? KIND_QUOT : KIND_AMP;
				held_len  = 3'd2;
			end else begin
				release_held();
				take_fresh(c);
			end
		end else begin
			want = spelled_char(held_kind, int'(held_len));
			if (want != CH_NUL && c == want) begin
				if (want == CH_SEMI) begin
					case (held_kind)
						KIND_LT:   put_char(CH_LT);
						KIND_GT:   put_char(CH_GT);
						KIND_QUOT: put_char(CH_QUOTE);
						default:   put_char(CH_AMP);
					endcase
					held_len  = 3'd0;
					held_kind = KIND_LT;
				end else begin
					held_len++;
				end
			end else begin
				// The match broke: the prefix goes out as text and this byte starts over.
				release_held();
				take_fresh(c);
			end
		end
		if (last)
			release_held();
	endtask

	task automatic add_row(input logic [7:0] c, input logic last, input logic typed,
	                       input logic [2:0] tn, input logic [7:0] tch);
		row_t r;
		r = '{c, last, typed, tn, tch};
		stimulus.insert(stimulus.size(), r);
	endtask

	// Offer one transaction, hold it until it is taken, then record what it should produce.
	task automatic send(input row_t r);
		char_t c;
		in_byte  <= r.ch;
		last_in  <= r.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		decode_step(r.ch, r.last);
		if (r.typed) begin
			for (int i = 0; i < int'(r.tn); i++) begin
				c = '{r.tch, 1'b1, r.last};
				decoded_due.insert(decoded_due.size(), c);
			end
		end else begin
			for (int i = 0; i < step_n; i++) begin
				c = '{step_chars[i], i == step_n - 1, (i == step_n - 1) && r.last};
				decoded_due.insert(decoded_due.size(), c);
			end
		end
	endtask

	// The timeout stands on its own so that a hung block always ends the run.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("** html_entity_decoder_core: FAILED **");
			$finish;
		end
	end

	// Output side: check every accepted transaction, then pick the stall for the next cycle.
	always @(posedge clk) begin
		char_t got;
		char_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{out_byte, run_end, text_end};
			if (decoded_due.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("cycle %0d: unexpected output byte %02h run_end %b text_end %b",
					         cycles, got.ch, got.run_end, got.text_end);
				mismatches++;
			end else begin
				want = decoded_due.pop_front();
				if (got !== want) begin
					if (mismatches < MAX_REPORTS)
						$display("cycle %0d: want %02h/%b/%b got %02h/%b/%b",
						         cycles, want.ch, want.run_end, want.text_end,
						         got.ch, got.run_end, got.text_end);
					mismatches++;
				end
			end
		end
		// The tail of the run sees no output stalls at all.
		if (calm)
			stall_left = 0;
		if (!calm && stall_left == 0 && $urandom_range(0, 9) == 0)
			stall_left = $urandom_range(1, 19);
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin
		logic [1:0] kind;
		logic [7:0] c;
		int         ent_len;
		int         cut;
		int         first_random;

		// Directed part: extremes, all four entities, a broken match after a doubled
		// ampersand, and a lone ampersand at the end of the text.
		add_row(8'h00,   1'b0, 1'b1, 3'd1, 8'h00);
		add_row(8'hFF,   1'b1, 1'b1, 3'd1, 8'hFF);
		add_row(CH_AMP,  1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_L,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_T,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_SEMI, 1'b0, 1'b1, 3'd1, CH_LT);
		add_row(CH_AMP,  1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_G,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_T,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_SEMI, 1'b0, 1'b1, 3'd1, CH_GT);
		add_row(CH_AMP,  1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_Q,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_U,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_O,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_T,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_SEMI, 1'b0, 1'b1, 3'd1, CH_QUOTE);
		add_row(CH_AMP,  1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_A,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_M,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_P,    1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_SEMI, 1'b0, 1'b1, 3'd1, CH_AMP);
		add_row(CH_AMP,  1'b0, 1'b1, 3'd0, CH_NUL);
		add_row(CH_AMP,  1'b0, 1'b0, 3'd0, CH_NUL);
		add_row(CH_Q,    1'b0, 1'b0, 3'd0, CH_NUL);
		add_row(8'h78,   1'b0, 1'b0, 3'd0, CH_NUL);
		add_row(CH_AMP,  1'b1, 1'b1, 3'd1, CH_AMP);

		// Random part: mostly whole or broken entities with plain text and stray
		// ampersands in between, so that every match depth is reached.
		first_random = stimulus.size();
		while (stimulus.size() - first_random < RANDOM_ITEMS) begin
			kind    = 2'($urandom_range(0, 3));
			ent_len = (kind == KIND_QUOT) ? 6 : (kind == KIND_AMP) ? 5 : 4;
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					for (int i = 0; i < ent_len; i++)
						add_row(spelled_char(kind, i), $urandom_range(0, 24) == 0,
						        1'b0, 3'd0, CH_NUL);
				end
				4, 5: begin
					cut = $urandom_range(1, ent_len - 1);
					for (int i = 0; i < cut; i++)
						add_row(spelled_char(kind, i), $urandom_range(0, 24) == 0,
						        1'b0, 3'd0, CH_NUL);
					c = $urandom_range(0, 1) ? CH_AMP : 8'($urandom_range(0, 255));
					add_row(c, $urandom_range(0, 24) == 0, 1'b0, 3'd0, CH_NUL);
				end
				6, 7: add_row(8'($urandom_range(0, 255)), $urandom_range(0, 24) == 0,
				              1'b0, 3'd0, CH_NUL);
				8: add_row(CH_AMP, $urandom_range(0, 24) == 0, 1'b0, 3'd0, CH_NUL);
				default: begin
					case ($urandom_range(0, 9))
						0: c = CH_L;
						1: c = CH_T;
						2: c = CH_G;
						3: c = CH_Q;
						4: c = CH_U;
						5: c = CH_O;
						6: c = CH_A;
						7: c = CH_M;
						8: c = CH_P;
						default: c = CH_SEMI;
					endcase
					add_row(c, $urandom_range(0, 24) == 0, 1'b0, 3'd0, CH_NUL);
				end
			endcase
		end
		// The text ends on the final byte so that any held prefix is flushed.
		stimulus[stimulus.size() - 1].last = 1'b1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int n = 0; n < stimulus.size(); n++) begin
			// The tail of the run goes without any idling on either side.
			calm = (n >= stimulus.size() - CALM_TAIL);
			if (!calm && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			send(stimulus[n]);
		end
		in_valid <= 1'b0;

		while (decoded_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && decoded_due.size() == 0) begin
			$display("** html_entity_decoder_core: PASSED **");
		end else begin
			$display("** html_entity_decoder_core: FAILED **");
		end
		$finish;
	end

endmodule
